/* rtl/cmcc_pkg.sv */
// shared constants and types of the three-c miss classifier
package cmcc_pkg;

  localparam int SETS_DEF      = 64;
  localparam int WAYS_DEF      = 4;
  localparam int LINE_BITS_DEF = 16;

  // lanes of the fully associative cache read per memory row
  localparam int FULL_LANES = 16;

  // bits per row of the seen-line bitmap
  localparam int SEEN_W  = 64;
  localparam int SEEN_BW = 6;

  localparam logic [3:0] LINE_SHIFT_RST = 4'd6;

  // register indexes
  localparam logic [0:0] REG_LINE_SHIFT = 1'b0;

  // result categories
  localparam logic [2:0] CAT_HIT  = 3'd0;
  localparam logic [2:0] CAT_COLD = 3'd1;
  localparam logic [2:0] CAT_CAP  = 3'd2;
  localparam logic [2:0] CAT_CONF = 3'd3;
  localparam logic [2:0] CAT_REJ  = 3'd4;

  typedef struct packed {
    logic start;
    logic flush;
  } full_cmd_t;

  typedef struct packed {
    logic done;
    logic hit;
  } full_rsp_t;

endpackage

/* rtl/cmcc_full_lru.sv */
// fully associative lru cache: row-wise search pass then rank update pass
module cmcc_full_lru #(
  parameter int TOTAL     = cmcc_pkg::SETS_DEF * cmcc_pkg::WAYS_DEF,
  parameter int LINE_BITS = cmcc_pkg::LINE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmcc_pkg::full_cmd_t   cmd,
  input  logic [LINE_BITS-1:0]  line,
  output cmcc_pkg::full_rsp_t   rsp
);

  localparam int LANES = cmcc_pkg::FULL_LANES;
  localparam int LW    = $clog2(LANES);
  localparam int ROWS  = (TOTAL + LANES - 1) / LANES;
  localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IW    = RAW + LW;
  localparam int RW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int PCW   = $clog2(ROWS + 1);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_SRCH = 2'd1;
  localparam logic [1:0] P_UPD  = 2'd2;

  logic [LANES*LINE_BITS-1:0] tag_mem  [ROWS];
  logic [LANES*RW-1:0]        rank_mem [ROWS];

  logic [LANES*LINE_BITS-1:0] tag_rd, tag_wr;
  logic [LANES*RW-1:0]        rank_rd, rank_wr;

  logic [1:0]           phase;
  logic [PCW-1:0]       pc;
  logic                 dv;
  logic [RAW-1:0]       drow;
  logic [IW:0]          fill;
  logic                 hit;
  logic [IW-1:0]        hit_idx;
  logic [RW-1:0]        hit_rank;
  logic [IW-1:0]        vict_idx;
  logic [LINE_BITS-1:0] line_q;

  logic                 rd_en;
  logic                 row_hit;
  logic [IW-1:0]        row_hit_idx;
  logic [RW-1:0]        row_hit_rank;
  logic                 row_vict;
  logic [IW-1:0]        row_vict_idx;
  logic [IW-1:0]        tgt;
  logic [RW:0]          thr;

  assign rd_en = (phase != P_IDLE) && (pc < PCW'(ROWS));

  // target entry and rank threshold of the update pass
  always_comb begin
    if (hit) begin
      tgt = hit_idx;
      thr = {1'b0, hit_rank};
    end else begin
      tgt = (fill < (IW+1)'(TOTAL)) ? fill[IW-1:0] : vict_idx;
      thr = (RW+1)'(TOTAL);
    end
  end

  // per-lane compare and new row
  always_comb begin
    logic [IW-1:0]        idx;
    logic                 vld;
    logic [LINE_BITS-1:0] tg;
    logic [RW-1:0]        rk;
    row_hit      = 1'b0;
    row_hit_idx  = '0;
    row_hit_rank = '0;
    row_vict     = 1'b0;
    row_vict_idx = '0;
    tag_wr       = tag_rd;
    rank_wr      = rank_rd;
    for (int l = 0; l < LANES; l++) begin
      idx = {drow, LW'(l)};
      vld = {1'b0, idx} < fill;
      tg  = tag_rd[l*LINE_BITS +: LINE_BITS];
      rk  = rank_rd[l*RW +: RW];
      if (vld && tg == line_q) begin
        row_hit      = 1'b1;
        row_hit_idx  = idx;
        row_hit_rank = rk;
      end
      if (vld && rk == RW'(TOTAL - 1)) begin
        row_vict     = 1'b1;
        row_vict_idx = idx;
      end
      if (idx == tgt) begin
        tag_wr[l*LINE_BITS +: LINE_BITS] = line_q;
        rank_wr[l*RW +: RW]              = '0;
      end else if (vld && {1'b0, rk} < thr) begin
        rank_wr[l*RW +: RW] = rk + 1'b1;
      end
    end
  end

  // row memories, one read and one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      tag_rd  <= tag_mem[pc[RAW-1:0]];
      rank_rd <= rank_mem[pc[RAW-1:0]];
    end
    if (phase == P_UPD && dv) begin
      tag_mem[drow]  <= tag_wr;
      rank_mem[drow] <= rank_wr;
    end
  end

  // pass sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      pc    <= '0;
      dv    <= 1'b0;
      fill  <= '0;
      hit   <= 1'b0;
    end else begin
      dv   <= rd_en;
      drow <= pc[RAW-1:0];
      case (phase)
        P_IDLE: begin
          if (cmd.flush) begin
            fill <= '0;
          end
          if (cmd.start) begin
            line_q <= line;
            pc     <= '0;
            hit    <= 1'b0;
            phase  <= P_SRCH;
          end
        end
        P_SRCH: begin
          if (rd_en) begin
            pc <= pc + 1'b1;
          end else begin
            pc    <= '0;
            phase <= P_UPD;
          end
          if (dv && row_hit) begin
            hit      <= 1'b1;
            hit_idx  <= row_hit_idx;
            hit_rank <= row_hit_rank;
          end
          if (dv && row_vict) begin
            vict_idx <= row_vict_idx;
          end
        end
        P_UPD: begin
          if (rd_en) begin
            pc <= pc + 1'b1;
          end else begin
            phase <= P_IDLE;
            if (!hit && fill < (IW+1)'(TOTAL)) begin
              fill <= fill + 1'b1;
            end
          end
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = (phase == P_UPD) && !rd_en;
  assign rsp.hit  = hit;

endmodule

/* rtl/cache_miss_three_c_classifier.sv */
// top level of the three-c miss classifier
//
//  channel  | direction | beat contents
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | tdata address[31:0], tlast last_access
//  m_*      | out       | tdata category, cold, capacity, conflict counts; tlast
//  apb      | cfg       | register 0 line_shift at byte address 0
//
// an item's time is set by the search and update passes of the fully associative
// cache over its 16-entry rows; the set index and set lookup run alongside. a
// rejected item skips both caches. reset, and every beat with tlast, start a
// clearing pass over the set and bitmap memories. a finished result waits in the
// output register; s_tready stays low only while an item is at work, while the
// pass runs, or while a result is held.
module cache_miss_three_c_classifier #(
  parameter int SETS      = cmcc_pkg::SETS_DEF,
  parameter int WAYS      = cmcc_pkg::WAYS_DEF,
  parameter int LINE_BITS = cmcc_pkg::LINE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // address[31:0]
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // category[2:0], cold[34:3], capacity[66:35],
                                  // conflict[98:67], zero[103:99]
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int TOTAL   = SETS * WAYS;
  localparam int SAW     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int AW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WFW     = $clog2(WAYS + 1);
  localparam int SBW     = cmcc_pkg::SEEN_BW;
  localparam int SROWS   = (2 ** LINE_BITS) / cmcc_pkg::SEEN_W;
  localparam int SRAW    = LINE_BITS - SBW;
  localparam int CLR_LEN = (SETS > SROWS) ? SETS : SROWS;
  localparam int CLW     = $clog2(CLR_LEN + 1);
  localparam int RL      = $clog2(SETS);
  localparam int RSH     = LINE_BITS + RL;
  localparam logic [LINE_BITS:0] RECIP =
    (LINE_BITS+1)'(((64'd1 << RSH) / 64'(SETS)) + 64'd1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MOD  = 3'd1;
  localparam logic [2:0] ST_SRD  = 3'd2;
  localparam logic [2:0] ST_SUPD = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;
  localparam logic [2:0] ST_CLR  = 3'd6;

  // memories
  logic [WFW-1:0]            set_fill_mem [SETS];
  logic [WAYS*LINE_BITS-1:0] set_tag_mem  [SETS];
  logic [WAYS*AW-1:0]        set_age_mem  [SETS];
  logic [cmcc_pkg::SEEN_W-1:0] seen_mem   [SROWS];

  logic [WFW-1:0]              sfill_rd, sfill_wr;
  logic [WAYS*LINE_BITS-1:0]   stag_rd, stag_wr;
  logic [WAYS*AW-1:0]          sage_rd, sage_wr;
  logic [cmcc_pkg::SEEN_W-1:0] seen_rd, seen_wr;

  logic [2:0]           state;
  logic [CLW-1:0]       clr_cnt;
  logic [3:0]           line_shift;
  logic [LINE_BITS-1:0] line_q;
  logic                 last_q;
  logic [SAW-1:0]       rem;
  logic [LINE_BITS-1:0] quot_q;
  logic                 mod_ph;
  logic                 set_hit_q;
  logic                 cold_q;
  logic                 fdone;
  logic                 fhit;
  logic [2:0]           cat_q;
  logic [31:0]          cold_cnt, cap_cnt, conf_cnt;
  logic [2:0]           out_cat;
  logic [31:0]          out_cold, out_cap, out_conf;

  logic [31:0]          shifted;
  logic                 reject;
  logic                 accept;
  logic                 load;
  logic                 clr_set, clr_seen;
  logic [2*LINE_BITS:0] prod;
  logic [31:0]          rem_full;
  logic                 set_hit;
  logic                 cold;
  logic [2:0]           cat;
  logic                 cfg_wr;

  cmcc_pkg::full_cmd_t  fcmd;
  cmcc_pkg::full_rsp_t  frsp;

  // input decode
  assign shifted  = s_tdata >> line_shift;
  assign reject   = |shifted[31:LINE_BITS];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load     = (state == ST_DONE) && (!m_tvalid || m_tready);

  // fully associative side runs alongside the set lookup
  assign fcmd.start = accept && !reject;
  assign fcmd.flush = load && last_q;

  cmcc_full_lru #(
    .TOTAL     (TOTAL),
    .LINE_BITS (LINE_BITS)
  ) u_full (
    .clk  (clk),
    .rst  (rst),
    .cmd  (fcmd),
    .line (shifted[LINE_BITS-1:0]),
    .rsp  (frsp)
  );

  // set index by reciprocal multiply: quotient first, remainder next cycle
  assign prod     = (2*LINE_BITS+1)'(line_q) * (2*LINE_BITS+1)'(RECIP);
  assign rem_full = 32'(line_q) - 32'(quot_q) * 32'(SETS);

  // set lookup over the ways of one row
  always_comb begin
    logic          vld;
    logic          hit;
    logic [AW-1:0] hit_way;
    logic [AW-1:0] hit_age;
    logic [AW-1:0] vict;
    logic [AW-1:0] tw;
    logic [AW:0]   thr;
    logic [AW-1:0] ag;
    hit     = 1'b0;
    hit_way = '0;
    hit_age = '0;
    vict    = '0;
    for (int w = 0; w < WAYS; w++) begin
      vld = WFW'(w) < sfill_rd;
      ag  = sage_rd[w*AW +: AW];
      if (vld && stag_rd[w*LINE_BITS +: LINE_BITS] == line_q) begin
        hit     = 1'b1;
        hit_way = AW'(w);
        hit_age = ag;
      end
      if (vld && ag == AW'(WAYS - 1)) begin
        vict = AW'(w);
      end
    end
    if (hit) begin
      tw  = hit_way;
      thr = {1'b0, hit_age};
    end else begin
      tw  = (sfill_rd < WFW'(WAYS)) ? sfill_rd[AW-1:0] : vict;
      thr = (AW+1)'(WAYS);
    end
    stag_wr = stag_rd;
    sage_wr = sage_rd;
    for (int w = 0; w < WAYS; w++) begin
      vld = WFW'(w) < sfill_rd;
      ag  = sage_rd[w*AW +: AW];
      if (AW'(w) == tw) begin
        stag_wr[w*LINE_BITS +: LINE_BITS] = line_q;
        sage_wr[w*AW +: AW]               = '0;
      end else if (vld && {1'b0, ag} < thr) begin
        sage_wr[w*AW +: AW] = ag + 1'b1;
      end
    end
    sfill_wr = (hit || sfill_rd == WFW'(WAYS)) ? sfill_rd : sfill_rd + 1'b1;
    set_hit  = hit;
  end

  // seen bitmap bit of this line
  assign cold    = !seen_rd[line_q[SBW-1:0]];
  assign seen_wr = seen_rd | ({{(cmcc_pkg::SEEN_W-1){1'b0}}, 1'b1} << line_q[SBW-1:0]);

  // category once both caches have answered
  always_comb begin
    if (set_hit_q) begin
      cat = cmcc_pkg::CAT_HIT;
    end else if (cold_q) begin
      cat = cmcc_pkg::CAT_COLD;
    end else if (!fhit) begin
      cat = cmcc_pkg::CAT_CAP;
    end else begin
      cat = cmcc_pkg::CAT_CONF;
    end
  end

  assign clr_set  = (state == ST_CLR) && (clr_cnt < CLW'(SETS));
  assign clr_seen = (state == ST_CLR) && (clr_cnt < CLW'(SROWS));

  // set and bitmap memories
  always_ff @(posedge clk) begin
    if (state == ST_SRD) begin
      sfill_rd <= set_fill_mem[rem];
      stag_rd  <= set_tag_mem[rem];
      sage_rd  <= set_age_mem[rem];
      seen_rd  <= seen_mem[line_q[LINE_BITS-1:SBW]];
    end
    if (clr_set) begin
      set_fill_mem[clr_cnt[SAW-1:0]] <= '0;
    end else if (state == ST_SUPD) begin
      set_fill_mem[rem] <= sfill_wr;
      set_tag_mem[rem]  <= stag_wr;
      set_age_mem[rem]  <= sage_wr;
    end
    if (clr_seen) begin
      seen_mem[clr_cnt[SRAW-1:0]] <= '0;
    end else if (state == ST_SUPD && !set_hit) begin
      seen_mem[line_q[LINE_BITS-1:SBW]] <= seen_wr;
    end
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == cmcc_pkg::REG_LINE_SHIFT) ? {28'd0, line_shift} : 32'd0;

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      clr_cnt    <= '0;
      line_shift <= cmcc_pkg::LINE_SHIFT_RST;
      cold_cnt   <= '0;
      cap_cnt    <= '0;
      conf_cnt   <= '0;
      m_tvalid   <= 1'b0;
      fdone      <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == cmcc_pkg::REG_LINE_SHIFT) begin
        line_shift <= pwdata[3:0];
      end
      if (frsp.done) begin
        fdone <= 1'b1;
        fhit  <= frsp.hit;
      end else if (accept) begin
        fdone <= 1'b0;
      end
      if (m_tvalid && m_tready && !load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            line_q <= shifted[LINE_BITS-1:0];
            last_q <= s_tlast;
            if (reject) begin
              cat_q <= cmcc_pkg::CAT_REJ;
              state <= ST_DONE;
            end else begin
              mod_ph <= 1'b0;
              state  <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          if (!mod_ph) begin
            quot_q <= LINE_BITS'(prod >> RSH);
            mod_ph <= 1'b1;
          end else begin
            rem   <= rem_full[SAW-1:0];
            state <= ST_SRD;
          end
        end
        ST_SRD: begin
          state <= ST_SUPD;
        end
        ST_SUPD: begin
          set_hit_q <= set_hit;
          cold_q    <= cold;
          state     <= ST_WAIT;
        end
        ST_WAIT: begin
          if (fdone) begin
            cat_q <= cat;
            if (cat == cmcc_pkg::CAT_COLD && cold_cnt != '1) begin
              cold_cnt <= cold_cnt + 1'b1;
            end
            if (cat == cmcc_pkg::CAT_CAP && cap_cnt != '1) begin
              cap_cnt <= cap_cnt + 1'b1;
            end
            if (cat == cmcc_pkg::CAT_CONF && conf_cnt != '1) begin
              conf_cnt <= conf_cnt + 1'b1;
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load) begin
            out_cat  <= cat_q;
            out_cold <= cold_cnt;
            out_cap  <= cap_cnt;
            out_conf <= conf_cnt;
            m_tlast  <= last_q;
            m_tvalid <= 1'b1;
            if (last_q) begin
              cold_cnt <= '0;
              cap_cnt  <= '0;
              conf_cnt <= '0;
              clr_cnt  <= '0;
              state    <= ST_CLR;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLW'(CLR_LEN - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {5'd0, out_conf, out_cap, out_cold, out_cat};

endmodule

/* rtl/cmcc_check.sv */
// port checker of the three-c miss classifier and its bind
module cmcc_check (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic         m_tlast,
  input logic         pready
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // categories stay within their codes and padding is zero
  a_cat_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= cmcc_pkg::CAT_REJ && m_tdata[103:99] == 5'd0)
    else $error("bad category or padding");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is at work");

  // the register port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready dropped");

endmodule

bind cache_miss_three_c_classifier cmcc_check u_cmcc_check (.*);

/* tb/tb_cmcc_checker.sv */
// predictor and result checker for the three-c miss classifier
`timescale 1ns / 1ps

module tb_cmcc_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [31:0]  s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,
  input  logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           pending,
  output int           errors
);

  localparam int LINES = cmcc_pkg::SETS_DEF * cmcc_pkg::WAYS_DEF;

  typedef struct packed {
    logic [2:0]  cat;
    logic [31:0] cold;
    logic [31:0] cap;
    logic [31:0] conf;
    logic        fin;
  } verdict_t;

  // entries 0..LINES-1 hold the set cache, LINES..2*LINES-1 the full cache
  logic [15:0] tags  [2*LINES];
  logic        valid [2*LINES];
  int          rank  [2*LINES];
  logic        seen  [1 << cmcc_pkg::LINE_BITS_DEF];
  logic [31:0] miss_cnt [3];
  logic [3:0]  shift_q;
  verdict_t    expected_q[$];

  function automatic void clear_trace();
    for (int i = 0; i < 2*LINES; i++) begin
      valid[i] = 1'b0;
      rank[i]  = 0;
    end
    for (int i = 0; i < (1 << cmcc_pkg::LINE_BITS_DEF); i++) seen[i] = 1'b0;
    for (int k = 0; k < 3; k++) miss_cnt[k] = '0;
  endfunction

  // lru lookup and update over n entries from base; 1 on hit
  function automatic bit lru_touch(int base, int n, logic [15:0] line);
    int slot;
    int oldest;
    int r;
    slot = -1;
    oldest = 0;
    for (int i = base; i < base + n; i++) begin
      if (valid[i] && tags[i] == line) begin
        r = rank[i];
        for (int j = base; j < base + n; j++)
          if (valid[j] && rank[j] < r) rank[j]++;
        rank[i] = 0;
        return 1'b1;
      end
    end
    for (int i = base; i < base + n; i++)
      if (!valid[i] && slot < 0) slot = i;
    if (slot < 0) begin
      slot = base;
      for (int i = base; i < base + n; i++)
        if (rank[i] >= oldest) begin
          oldest = rank[i];
          slot = i;
        end
    end
    for (int i = base; i < base + n; i++)
      if (valid[i] && i != slot) rank[i]++;
    tags[slot]  = line;
    valid[slot] = 1'b1;
    rank[slot]  = 0;
    return 1'b0;
  endfunction

  function automatic verdict_t classify_access(logic [31:0] addr, logic last);
    verdict_t v;
    logic [31:0] line;
    bit set_hit;
    bit fa_hit;
    line = addr >> shift_q;
    if ((line >> cmcc_pkg::LINE_BITS_DEF) != 0) begin
      v.cat = cmcc_pkg::CAT_REJ;
    end else begin
      set_hit = lru_touch((line % cmcc_pkg::SETS_DEF) * cmcc_pkg::WAYS_DEF,
                          cmcc_pkg::WAYS_DEF, line[15:0]);
      fa_hit  = lru_touch(LINES, LINES, line[15:0]);
      if (set_hit) begin
        v.cat = cmcc_pkg::CAT_HIT;
      end else begin
        if (!seen[line[15:0]]) v.cat = cmcc_pkg::CAT_COLD;
        else if (!fa_hit) v.cat = cmcc_pkg::CAT_CAP;
        else v.cat = cmcc_pkg::CAT_CONF;
        seen[line[15:0]] = 1'b1;
        if (miss_cnt[v.cat - 1] != 32'hFFFF_FFFF) miss_cnt[v.cat - 1]++;
      end
    end
    v.cold = miss_cnt[0];
    v.cap  = miss_cnt[1];
    v.conf = miss_cnt[2];
    v.fin  = last;
    if (last) clear_trace();
    return v;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      clear_trace();
      shift_q = cmcc_pkg::LINE_SHIFT_RST;
      expected_q.delete();
      pending = 0;
    end else begin
      // register write
      if (psel && penable && pwrite && pready && paddr[2] == cmcc_pkg::REG_LINE_SHIFT)
        shift_q = pwdata[3:0];
      // accepted address beat
      if (s_tvalid && s_tready)
        expected_q.push_back(classify_access(s_tdata, s_tlast));
      // result beat against the oldest expectation
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected beat", 32'(m_tdata[2:0]), 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[2:0] !== want.cat)
            report("category", 32'(m_tdata[2:0]), 32'(want.cat));
          if (m_tdata[34:3] !== want.cold) report("cold", m_tdata[34:3], want.cold);
          if (m_tdata[66:35] !== want.cap) report("capacity", m_tdata[66:35], want.cap);
          if (m_tdata[98:67] !== want.conf) report("conflict", m_tdata[98:67], want.conf);
          if (m_tlast !== want.fin) report("last", 32'(m_tlast), 32'(want.fin));
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

/* tb/tb_cache_miss_three_c_classifier.sv */
// stimulus and verdict for the three-c miss classifier
`timescale 1ns / 1ps

module tb_cache_miss_three_c_classifier;

  localparam int LIMIT = 1_000_000;
  localparam int ITEMS = 1450;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [31:0]  s_tdata;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;
  logic         m_tlast;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  int           pending;
  int           errors;
  int           cycles;
  int           burst_left;
  int           sent;
  logic [3:0]   shift_now;

  cache_miss_three_c_classifier DUT (.*);

  tb_cmcc_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_cache_miss_three_c_classifier: errors");
      $finish;
    end
  end

  // receiver stalls: windows of random stalls and windows of none
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (cycles[9]) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic apb_write(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {cmcc_pkg::REG_LINE_SHIFT, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    shift_now = value[3:0];
  endtask

  // one address beat, sent in bursts with gaps between them
  task automatic send_beat(logic [31:0] addr, logic last);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= addr;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  function automatic logic [31:0] line_addr(logic [15:0] line);
    logic [31:0] off;
    off = $urandom & ((32'd1 << shift_now) - 1);
    return ({16'd0, line} << shift_now) | off;
  endfunction

  // drain results and let any clearing pass finish
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  // one trace of a given access pattern, ending with tlast
  task automatic run_trace(int kind, int len);
    logic [15:0] pool [16];
    logic [15:0] line;
    logic [31:0] addr;
    int          set_sel;
    set_sel = $urandom_range(0, cmcc_pkg::SETS_DEF - 1);
    for (int i = 0; i < 16; i++) pool[i] = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: line = pool[$urandom_range(0, 15)];
        1: line = 16'(set_sel + cmcc_pkg::SETS_DEF * $urandom_range(0, 7));
        2: line = 16'((i % 300) + ($urandom_range(0, 9) == 0 ? $urandom_range(0, 40) : 0));
        default: line = 16'($urandom_range(0, 1023));
      endcase
      addr = line_addr(line);
      if ($urandom_range(0, 9) == 0) addr = $urandom;
      send_beat(addr, i == len - 1);
    end
  endtask

  initial begin
    int shifts [6];
    int goal;
    int kind;
    int len;
    shifts = '{0, 12, 15, 3, 13, 6};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    burst_left = 0;
    sent = 0;
    shift_now = cmcc_pkg::LINE_SHIFT_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (1200) @(posedge clk);

    // directed: cold, hit, range edges, conflict in one set, end of trace
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'h0000_003F, 1'b0);
    send_beat(32'hFFFF_FFFF, 1'b0);
    send_beat(32'h003F_FFFF, 1'b0);
    send_beat(32'h0040_0000, 1'b0);
    for (int k = 1; k <= 4; k++) send_beat(32'(k * 64) << 6, 1'b0);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'h0000_1000, 1'b0);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'hFFFF_FFFF, 1'b1);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'h0000_0000, 1'b1);
    settle();

    // phases over several line sizes, extremes among them
    foreach (shifts[p]) begin
      apb_write(32'(shifts[p]));
      goal = sent + ITEMS / 6;
      while (sent < goal) begin
        kind = $urandom_range(0, 3);
        len  = (kind == 2) ? $urandom_range(320, 420) : $urandom_range(20, 120);
        if (len > goal - sent) len = goal - sent;
        run_trace(kind, len);
      end
      settle();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb_cache_miss_three_c_classifier: clean");
    else $display("tb_cache_miss_three_c_classifier: errors");
    $finish;
  end

endmodule
